// ===== hw/rtl/cau_pkg.sv =====
// Shared types and codes for the complex arithmetic unit.
package cau_pkg;

  localparam int DATA_BITS = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cau_op_t;

  typedef struct packed {
    cau_op_t                     op;
    logic signed [DATA_BITS-1:0] a_real;
    logic signed [DATA_BITS-1:0] a_imag;
    logic signed [DATA_BITS-1:0] b_real;
    logic signed [DATA_BITS-1:0] b_imag;
  } cau_in_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] res_real;
    logic signed [DATA_BITS-1:0] res_imag;
    logic                        div_zero;
    logic                        saturated;
  } cau_out_t;

endpackage

// ===== hw/rtl/complex_arith_unit.sv =====
// Complex add/sub/mul/div in signed fixed point, one beat in per cycle while in_stall is low.
// Throughput: one beat per cycle while out_stall is low; the divider retires one quotient bit per stage.
// A two-beat queue lets the front end accept beats while the output is stalled, until the queue fills.
// Reset (rst_n low, synchronous) empties the pipeline and the queue.
module complex_arith_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cau_pkg::cau_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cau_pkg::cau_out_t out_data
);
  import cau_pkg::*;

  localparam int QW      = 2 + 2 * (WORD_BITS + 1) + 12 * WORD_BITS;
  localparam int Q_DEPTH = 2;

  logic          q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_wdata, q_head;

  cau_front #(.W(WORD_BITS), .QW(QW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  cau_fifo #(.WIDTH(QW), .DEPTH(Q_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  cau_back #(.W(WORD_BITS), .F(FRAC_BITS), .QW(QW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/cau_front.sv =====
// Front end: accepts operand beats, forms sums or differences and exact products, feeds the queue.
module cau_front #(
  parameter int W  = 32,
  parameter int QW = 2 + 2 * (W + 1) + 12 * W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  cau_pkg::cau_in_t in_data,
  output logic             q_push,
  output logic [QW-1:0]    q_data,
  input  logic             q_full
);
  import cau_pkg::*;

  localparam int PW = 2 * W;

  typedef struct packed {
    cau_op_t              op;
    logic signed [W:0]    sum_re;
    logic signed [W:0]    sum_im;
    logic signed [PW-1:0] p_rr;
    logic signed [PW-1:0] p_ii;
    logic signed [PW-1:0] p_ri;
    logic signed [PW-1:0] p_ir;
    logic signed [PW-1:0] p_br2;
    logic signed [PW-1:0] p_bi2;
  } fq_t;

  logic signed [W-1:0] ar, ai, br, bi;
  logic                f_vld_r;
  fq_t                 f_data_r, f_data_nxt;
  logic                adv;

  assign ar = signed'(in_data.a_real[W-1:0]);
  assign ai = signed'(in_data.a_imag[W-1:0]);
  assign br = signed'(in_data.b_real[W-1:0]);
  assign bi = signed'(in_data.b_imag[W-1:0]);

  always_comb begin
    f_data_nxt.op = in_data.op;
    if (in_data.op == OP_SUB) begin
      f_data_nxt.sum_re = (W+1)'(ar) - (W+1)'(br);
      f_data_nxt.sum_im = (W+1)'(ai) - (W+1)'(bi);
    end else begin
      f_data_nxt.sum_re = (W+1)'(ar) + (W+1)'(br);
      f_data_nxt.sum_im = (W+1)'(ai) + (W+1)'(bi);
    end
    f_data_nxt.p_rr  = PW'(ar) * PW'(br);
    f_data_nxt.p_ii  = PW'(ai) * PW'(bi);
    f_data_nxt.p_ri  = PW'(ar) * PW'(bi);
    f_data_nxt.p_ir  = PW'(ai) * PW'(br);
    f_data_nxt.p_br2 = PW'(br) * PW'(br);
    f_data_nxt.p_bi2 = PW'(bi) * PW'(bi);
  end

  assign adv      = !f_vld_r || !q_full;
  assign in_stall = !adv;
  assign q_push   = f_vld_r && !q_full;
  assign q_data   = QW'(f_data_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      f_data_r <= f_data_nxt;
    end
  end

endmodule

// ===== hw/rtl/cau_fifo.sv =====
// Short queue between the front end and the back end.
module cau_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [AW:0]      cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/cau_back.sv =====
// Back end: combines products, saturates, and runs the pipelined restoring divider.
module cau_back #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int QW = 2 + 2 * (W + 1) + 12 * W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  logic [QW-1:0]     q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output cau_pkg::cau_out_t out_data
);
  import cau_pkg::*;

  localparam int PW = 2 * W;
  localparam int SW = PW + 1;
  localparam int NW = SW + F;
  localparam int DW = PW;
  localparam int HW = NW - W;
  localparam int CW = (HW > DW) ? HW : DW;
  localparam int RW = DW + 1;

  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    cau_op_t              op;
    logic signed [W:0]    sum_re;
    logic signed [W:0]    sum_im;
    logic signed [PW-1:0] p_rr;
    logic signed [PW-1:0] p_ii;
    logic signed [PW-1:0] p_ri;
    logic signed [PW-1:0] p_ir;
    logic signed [PW-1:0] p_br2;
    logic signed [PW-1:0] p_bi2;
  } fq_t;

  typedef struct packed {
    cau_op_t      op;
    logic         dz;
    logic         neg_re;
    logic         neg_im;
    logic [W-1:0] r_re;
    logic [W-1:0] r_im;
    logic         r_sat;
  } sb_t;

  function automatic logic [W:0] clamp_w(input logic signed [SW-1:0] v);
    logic [SW-W:0] hi;
    logic          fits;
    hi   = v[SW-1:W-1];
    fits = (&hi) || !(|hi);
    if (fits) return {1'b0, v[W-1:0]};
    return {1'b1, v[SW-1] ? WMIN : WMAX};
  endfunction

  function automatic logic [W:0] div_fix(input logic neg, input logic ovf,
                                          input logic [W-1:0] q);
    if (ovf) return {1'b1, neg ? WMIN : WMAX};
    if (!neg) begin
      if (q[W-1]) return {1'b1, WMAX};
      return {1'b0, q};
    end
    if (q[W-1] && (|q[W-2:0])) return {1'b1, WMIN};
    return {1'b0, W'(-q)};
  endfunction

  fq_t qh;
  logic adv;

  assign qh    = fq_t'(q_head);
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && !q_empty;

  // Stage A: wide real/imag terms and |b|^2
  logic                 a_vld_r;
  cau_op_t              a_op_r;
  logic signed [SW-1:0] a_re_r, a_im_r, a_re_nxt, a_im_nxt;
  logic [DW-1:0]        a_den_r;

  always_comb begin
    unique case (qh.op)
      OP_ADD, OP_SUB: begin
        a_re_nxt = SW'(qh.sum_re);
        a_im_nxt = SW'(qh.sum_im);
      end
      OP_MUL: begin
        a_re_nxt = SW'(qh.p_rr) - SW'(qh.p_ii);
        a_im_nxt = SW'(qh.p_ri) + SW'(qh.p_ir);
      end
      OP_DIV: begin
        a_re_nxt = SW'(qh.p_rr) + SW'(qh.p_ii);
        a_im_nxt = SW'(qh.p_ir) - SW'(qh.p_ri);
      end
      default: begin
        a_re_nxt = '0;
        a_im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r  <= qh.op;
      a_re_r  <= a_re_nxt;
      a_im_r  <= a_im_nxt;
      a_den_r <= DW'(qh.p_br2) + DW'(qh.p_bi2);
    end
  end

  // Stage B: saturate non-divide results, form divide magnitudes
  logic                 b_vld_r;
  sb_t                  b_sb_r, b_sb_nxt;
  logic [NW-1:0]        b_mag_re_r, b_mag_im_r;
  logic [DW-1:0]        b_den_r;
  logic signed [NW-1:0] num_re, num_im;
  logic [W:0]           cl_re, cl_im;

  always_comb begin
    num_re = NW'(a_re_r) <<< F;
    num_im = NW'(a_im_r) <<< F;
    if (a_op_r == OP_MUL) begin
      cl_re = clamp_w(a_re_r >>> F);
      cl_im = clamp_w(a_im_r >>> F);
    end else begin
      cl_re = clamp_w(a_re_r);
      cl_im = clamp_w(a_im_r);
    end
    b_sb_nxt.op     = a_op_r;
    b_sb_nxt.dz     = (a_den_r == '0);
    b_sb_nxt.neg_re = a_re_r[SW-1];
    b_sb_nxt.neg_im = a_im_r[SW-1];
    b_sb_nxt.r_re   = cl_re[W-1:0];
    b_sb_nxt.r_im   = cl_im[W-1:0];
    b_sb_nxt.r_sat  = cl_re[W] | cl_im[W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sb_r     <= b_sb_nxt;
      b_den_r    <= a_den_r;
      b_mag_re_r <= a_re_r[SW-1] ? NW'(-num_re) : NW'(num_re);
      b_mag_im_r <= a_im_r[SW-1] ? NW'(-num_im) : NW'(num_im);
    end
  end

  // Divider: stage 0 checks overflow, stages 1..W each retire one quotient bit
  logic          d_vld_r    [0:W];
  sb_t           d_sb_r     [0:W];
  logic [DW-1:0] d_den_r    [0:W];
  logic [RW-1:0] d_rem_re_r [0:W];
  logic [RW-1:0] d_rem_im_r [0:W];
  logic [W-1:0]  d_low_re_r [0:W];
  logic [W-1:0]  d_low_im_r [0:W];
  logic [W-1:0]  d_q_re_r   [0:W];
  logic [W-1:0]  d_q_im_r   [0:W];
  logic          d_ovf_re_r [0:W];
  logic          d_ovf_im_r [0:W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r[0] <= 1'b0;
    end else if (adv) begin
      d_vld_r[0] <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_sb_r[0]     <= b_sb_r;
      d_den_r[0]    <= b_den_r;
      d_ovf_re_r[0] <= CW'(b_mag_re_r >> W) >= CW'(b_den_r);
      d_ovf_im_r[0] <= CW'(b_mag_im_r >> W) >= CW'(b_den_r);
      d_rem_re_r[0] <= RW'(b_mag_re_r >> W);
      d_rem_im_r[0] <= RW'(b_mag_im_r >> W);
      d_low_re_r[0] <= b_mag_re_r[W-1:0];
      d_low_im_r[0] <= b_mag_im_r[W-1:0];
      d_q_re_r[0]   <= '0;
      d_q_im_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_div
    logic [RW-1:0] t_re, t_im, dd;
    logic          ge_re, ge_im;

    assign dd    = {1'b0, d_den_r[k-1]};
    assign t_re  = {d_rem_re_r[k-1][DW-1:0], d_low_re_r[k-1][W-1]};
    assign t_im  = {d_rem_im_r[k-1][DW-1:0], d_low_im_r[k-1][W-1]};
    assign ge_re = (t_re >= dd);
    assign ge_im = (t_im >= dd);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_vld_r[k] <= 1'b0;
      end else if (adv) begin
        d_vld_r[k] <= d_vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_sb_r[k]     <= d_sb_r[k-1];
        d_den_r[k]    <= d_den_r[k-1];
        d_ovf_re_r[k] <= d_ovf_re_r[k-1];
        d_ovf_im_r[k] <= d_ovf_im_r[k-1];
        d_rem_re_r[k] <= ge_re ? t_re - dd : t_re;
        d_rem_im_r[k] <= ge_im ? t_im - dd : t_im;
        d_low_re_r[k] <= {d_low_re_r[k-1][W-2:0], 1'b0};
        d_low_im_r[k] <= {d_low_im_r[k-1][W-2:0], 1'b0};
        d_q_re_r[k]   <= {d_q_re_r[k-1][W-2:0], ge_re};
        d_q_im_r[k]   <= {d_q_im_r[k-1][W-2:0], ge_im};
      end
    end
  end

  // Output register
  logic       out_vld_r;
  cau_out_t   out_r, out_nxt;
  logic [W:0] fx_re, fx_im;
  sb_t        sb_w;

  assign sb_w  = d_sb_r[W];
  assign fx_re = div_fix(sb_w.neg_re, d_ovf_re_r[W], d_q_re_r[W]);
  assign fx_im = div_fix(sb_w.neg_im, d_ovf_im_r[W], d_q_im_r[W]);

  always_comb begin
    out_nxt.div_zero = 1'b0;
    if (sb_w.op == OP_DIV) begin
      if (sb_w.dz) begin
        out_nxt.res_real  = '0;
        out_nxt.res_imag  = '0;
        out_nxt.div_zero  = 1'b1;
        out_nxt.saturated = 1'b0;
      end else begin
        out_nxt.res_real  = DATA_BITS'(signed'(fx_re[W-1:0]));
        out_nxt.res_imag  = DATA_BITS'(signed'(fx_im[W-1:0]));
        out_nxt.saturated = fx_re[W] | fx_im[W];
      end
    end else begin
      out_nxt.res_real  = DATA_BITS'(signed'(sb_w.r_re));
      out_nxt.res_imag  = DATA_BITS'(signed'(sb_w.r_im));
      out_nxt.saturated = sb_w.r_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= d_vld_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && d_vld_r[W]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/cau_checker.sv =====
// Port-level checks for the complex arithmetic unit, bound to the top level.
module cau_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input cau_pkg::cau_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input cau_pkg::cau_out_t out_data
);
  import cau_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out beat changed while stalled");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_zero |->
      out_data.res_real == '0 && out_data.res_imag == '0 && !out_data.saturated)
    else $error("divide by zero beat carries nonzero result or saturation");

  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("out_valid high right after reset");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the complex arithmetic unit.
`timescale 1ns / 1ps

module tb_top;
  import cau_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 38;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  cau_in_t in_data;
  logic out_valid;
  logic out_stall;
  cau_out_t out_data;

  cau_out_t result_queue[$];
  int errors;
  int idle_cycles;
  bit quiet_mode;

  complex_arith_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Clamp a wide signed value to 32 bits; flag the clamp.
  function automatic logic signed [31:0] clamp32(input logic signed [129:0] v,
                                                 inout logic sat);
    if (v > 130'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -130'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Divide toward zero by a positive denominator.
  function automatic logic signed [129:0] div_trunc(input logic signed [129:0] num,
                                                    input logic signed [129:0] den);
    logic signed [129:0] mag;
    logic signed [129:0] q;
    mag = (num < 0) ? -num : num;
    q = mag / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic cau_out_t complex_result(input cau_in_t item);
    cau_out_t r;
    logic sat;
    logic signed [129:0] ar, ai, br, bi, re, im, den;
    ar = item.a_real; ai = item.a_imag; br = item.b_real; bi = item.b_imag;
    sat = 1'b0;
    r = '0;
    unique case (item.op)
      OP_ADD: begin
        r.res_real = clamp32(ar + br, sat);
        r.res_imag = clamp32(ai + bi, sat);
      end
      OP_SUB: begin
        r.res_real = clamp32(ar - br, sat);
        r.res_imag = clamp32(ai - bi, sat);
      end
      OP_MUL: begin
        re = ar * br - ai * bi;
        im = ar * bi + ai * br;
        r.res_real = clamp32(re >>> FRAC, sat);
        r.res_imag = clamp32(im >>> FRAC, sat);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_zero = 1'b1;
        end else begin
          re = (ar * br + ai * bi) <<< FRAC;
          im = (ai * br - ar * bi) <<< FRAC;
          r.res_real = clamp32(div_trunc(re, den), sat);
          r.res_imag = clamp32(div_trunc(im, den), sat);
        end
      end
    endcase
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit idle_now();
    return !quiet_mode && ($urandom_range(99) < 7);
  endfunction

  // Send one beat and hold it until accepted.
  task automatic send_item(input cau_in_t item);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    result_queue.push_back(complex_result(item));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_ops(input logic [31:0] ar, ai, br, bi);
    cau_in_t item;
    item.a_real = ar; item.a_imag = ai; item.b_real = br; item.b_imag = bi;
    for (int k = 0; k < 4; k++) begin
      item.op = cau_op_t'(k);
      send_item(item);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (result_queue.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_ops(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hffff_0000);
    send_ops(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_ops(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_ops(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0);
    send_ops(32'hffff_ffff, 32'h1, 32'h1, 32'h0);
    send_ops(32'h1234_5678, 32'hedcb_a987, 32'h8000_0000, 32'h7fff_ffff);
  endtask

  function automatic logic [31:0] rand_part();
    case ($urandom_range(4))
      0: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      1: return $urandom_range(2) - 1;
      2: return {{16{1'b0}}, 16'($urandom)} - 32'h8000 + ($urandom_range(8) << 16);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random(input int count);
    cau_in_t item;
    for (int n = 0; n < count; n++) begin
      item.op = cau_op_t'($urandom_range(3));
      item.a_real = rand_part(); item.a_imag = rand_part();
      item.b_real = rand_part(); item.b_imag = rand_part();
      if ($urandom_range(19) == 0) begin
        item.b_real = '0;
        item.b_imag = '0;
      end
      send_item(item);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    errors = 0;
    quiet_mode = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(150);
    drain();
    quiet_mode = 1'b1;
    test_random(150);
    quiet_mode = 1'b0;
    test_random(150);
    drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0 && result_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= idle_now();
    end
  end

  // Check each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    cau_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_queue.size() == 0) begin
        report_mismatch("unexpected beat", out_data.res_real, 32'h0);
      end else begin
        want = result_queue.pop_front();
        if (out_data.res_real !== want.res_real)
          report_mismatch("res_real", out_data.res_real, want.res_real);
        if (out_data.res_imag !== want.res_imag)
          report_mismatch("res_imag", out_data.res_imag, want.res_imag);
        if (out_data.div_zero !== want.div_zero)
          report_mismatch("div_zero", 32'(out_data.div_zero), 32'(want.div_zero));
        if (out_data.saturated !== want.saturated)
          report_mismatch("saturated", 32'(out_data.saturated), 32'(want.saturated));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
